// File: hw/rtl/bltd_pkg.sv
// Shared constants, types and decode functions for the byte-level token text decoder.
package bltd_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_RES    = 4;
    localparam int RES_CNT_W  = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int CP_W       = 21;

    // Sequence lengths, as held in the needed-length register
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN1     = 3'd1;
    localparam logic [2:0] LEN2     = 3'd2;
    localparam logic [2:0] LEN3     = 3'd3;
    localparam logic [2:0] LEN4     = 3'd4;

    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Offsets of the relocated byte ranges above code point 256
    localparam logic [7:0] LOW_CTRL_END  = 8'd33;
    localparam logic [7:0] HIGH_CTRL_END = 8'd67;
    localparam logic [7:0] HIGH_CTRL_OFS = 8'd94;
    localparam logic [7:0] SOFT_HYPHEN   = 8'd173;

    typedef struct packed {
        logic             hit;
        logic [BYTE_W-1:0] value;
    } map_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } res_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & ASCII_MASK) == 8'h00)
            len = LEN1;
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = LEN2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = LEN3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = LEN4;
        else
            len = LEN1;
        return len;
    endfunction

    // Reverse byte map for code points below 512
    function automatic map_t rev_map(input logic [8:0] cp);
        map_t       m;
        logic [7:0] n;
        n       = cp[7:0];
        m.hit   = 1'b0;
        m.value = n;
        if (!cp[8]) begin
            m.hit = n inside {[8'd33:8'd126], [8'd161:8'd172], [8'd174:8'd255]};
        end else if (n < LOW_CTRL_END) begin
            m.hit = 1'b1;
        end else if (n < HIGH_CTRL_END) begin
            m.hit   = 1'b1;
            m.value = n + HIGH_CTRL_OFS;
        end else if (n == HIGH_CTRL_END) begin
            m.hit   = 1'b1;
            m.value = SOFT_HYPHEN;
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/bltd_in_if.sv
// Input channel: one byte of a token string per item, with an end-of-string flag.
interface bltd_in_if;
    import bltd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              string_end;

    modport source (output valid, output text_byte, output string_end, input ready);
    modport sink (input valid, input text_byte, input string_end, output ready);
endinterface

// File: hw/rtl/bltd_out_if.sv
// Output channel: one decoded or raw byte per item, flagged on the last of its run.
interface bltd_out_if;
    import bltd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// File: hw/rtl/byte_level_token_text_decode_core.sv
// Results of an item are written to the result queue at the accepting edge; if the queue
// was empty, the first one is offered on the output in the next cycle.
// Throughput: one input item per cycle while the 8-entry result queue has room for four
// results; one result leaves per cycle while the output is ready. An item may give zero to four results.
// Reset clears the open-sequence count and length and empties the result queue.
module byte_level_token_text_decode_core (
    input  logic      clk,
    input  logic      rst_n,
    bltd_in_if.sink   in_ch,
    bltd_out_if.source out_ch
);
    import bltd_pkg::*;

    logic [BYTE_W-1:0] pend_reg [3];
    logic [BYTE_W-1:0] pend_next [3];
    logic [1:0]        cnt_reg, cnt_next;
    logic [2:0]        need_reg, need_next;

    res_t              fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic              in_acc, out_acc;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] q [4];
    logic [BYTE_W-1:0] res [MAX_RES];
    logic [RES_CNT_W-1:0] res_cnt;
    logic [2:0]        n_len;
    logic [CP_W-1:0]   full_cp;
    logic              full_small, tail_small;
    map_t              full_map, tail_map;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign b       = in_ch.text_byte;

    assign in_ch.ready     = fill_reg <= FILL_W'(FIFO_DEPTH - MAX_RES);
    assign out_ch.valid    = fill_reg != '0;
    assign out_ch.out_byte = fifo_reg[rd_ptr_reg].value;
    assign out_ch.run_last = fifo_reg[rd_ptr_reg].last;

    // Held bytes followed by the incoming byte
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q[i] = (2'(i) < cnt_reg) ? pend_reg[i] : b;
        end
        q[3]  = b;
        n_len = {1'b0, cnt_reg} + 3'd1;
    end

    always_comb
    begin
        case (need_reg)
            LEN2:    full_cp = {10'd0, q[0][4:0], q[1][5:0]};
            LEN3:    full_cp = {5'd0, q[0][3:0], q[1][5:0], q[2][5:0]};
            LEN4:    full_cp = {q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
            default: full_cp = '0;
        endcase
        full_small = full_cp[CP_W-1:9] == '0;
        full_map   = rev_map(full_cp[8:0]);
        // Two-byte sequence re-parsed after a truncated lead
        tail_small = q[1][4:3] == 2'b00;
        tail_map   = rev_map({q[1][2:0], q[2][5:0]});
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        cnt_next  = cnt_reg;
        need_next = need_reg;
        res_cnt   = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = q[i];
        end

        if (need_reg == LEN_NONE) begin
            if (lead_len(b) != LEN1 && !in_ch.string_end) begin
                pend_next[0] = b;
                cnt_next     = 2'd1;
                need_next    = lead_len(b);
            end else begin
                // A lone byte always comes out as itself
                res[0]  = b;
                res_cnt = RES_CNT_W'(1);
            end
        end else if (!in_ch.string_end && n_len < need_reg) begin
            pend_next[cnt_reg] = b;
            cnt_next           = cnt_reg + 2'd1;
        end else begin
            cnt_next  = '0;
            need_next = LEN_NONE;
            if (n_len == need_reg) begin
                if (full_small && full_map.hit) begin
                    res[0]  = full_map.value;
                    res_cnt = RES_CNT_W'(1);
                end else begin
                    res_cnt = n_len;
                end
            end else begin
                // String ended early: lead goes out raw; only a two-byte tail is parsed again
                res_cnt = n_len;
                if (n_len == LEN3 && lead_len(q[1]) == LEN2 && tail_small && tail_map.hit) begin
                    res[1]  = tail_map.value;
                    res_cnt = RES_CNT_W'(2);
                end
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (in_acc)
            fill_next = fill_next + FILL_W'(res_cnt);
        if (out_acc)
            fill_next = fill_next - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            need_reg   <= LEN_NONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (in_acc) begin
                cnt_reg    <= cnt_next;
                need_reg   <= need_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_cnt);
            end
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++)
            begin
                pend_reg[i] <= pend_next[i];
            end
            for (int k = 0; k < MAX_RES; k++)
            begin
                if (RES_CNT_W'(k) < res_cnt) begin
                    fifo_reg[wr_ptr_reg + PTR_W'(k)] <= '{value: res[k],
                        last: (RES_CNT_W'(k) == res_cnt - RES_CNT_W'(1))};
                end
            end
        end
    end

endmodule
